// ===== sv/integer_matrix_multiply_macros.svh =====
`ifndef INTEGER_MATRIX_MULTIPLY_MACROS_SVH
`define INTEGER_MATRIX_MULTIPLY_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define IMM_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define IMM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/imm_pkg.sv =====
package imm_pkg;

	localparam int DATA_W = 32;
	localparam int IDX_W  = 3;
	localparam int DIM_W  = 4;
	localparam int CFG_AW = 2;

	localparam logic [1:0] OP_LOAD_A = 2'd0;
	localparam logic [1:0] OP_LOAD_B = 2'd1;
	localparam logic [1:0] OP_START  = 2'd2;

	localparam logic [CFG_AW-1:0] REG_A_ROWS = 2'd0;
	localparam logic [CFG_AW-1:0] REG_A_COLS = 2'd1;
	localparam logic [CFG_AW-1:0] REG_B_ROWS = 2'd2;
	localparam logic [CFG_AW-1:0] REG_B_COLS = 2'd3;

	localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

	typedef struct packed {
		logic [1:0]               op;
		logic [IDX_W-1:0]         row;
		logic [IDX_W-1:0]         col;
		logic signed [DATA_W-1:0] value;
	} in_t;

	typedef struct packed {
		logic [IDX_W-1:0]         out_row;
		logic [IDX_W-1:0]         out_col;
		logic signed [DATA_W-1:0] result;
		logic                     last;
		logic                     status;
	} out_t;

	// One element of A travelling down the cell row.
	typedef struct packed {
		logic              vld;
		logic [DATA_W-1:0] a;
		logic [IDX_W-1:0]  k;
		logic              first;
		logic              lastk;
	} tok_t;

	// Broadcast write of one element of B.
	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic [DATA_W-1:0] value;
	} bwr_t;

endpackage

// ===== sv/imm_cell.sv =====
module imm_cell import imm_pkg::*; #(
	parameter int DIM_CAP = 8,
	parameter int J = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tok_t              tok_i,
	input  bwr_t              bwr,
	output tok_t              tok_o,
	output logic [DATA_W-1:0] acc
);

	localparam int KW = (DIM_CAP > 1) ? $clog2(DIM_CAP) : 1;

	logic [DATA_W-1:0]   b_q [DIM_CAP];
	logic [DATA_W-1:0]   b_sel;
	logic [2*DATA_W-1:0] mul;
	tok_t                tok_s1;
	logic [DATA_W-1:0]   prod_s1;
	logic [DATA_W-1:0]   acc_q;

	// This cell keeps column J of B.
	always_ff @(posedge clk) begin
		if (bwr.we && (int'(bwr.col) == J)) begin
			b_q[bwr.row[KW-1:0]] <= bwr.value;
		end
	end

	assign b_sel = b_q[tok_i.k[KW-1:0]];
	assign mul   = tok_i.a * b_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
		end else begin
			tok_s1 <= tok_i;
		end
	end

	// Only the low word of the product matters for a wrapping sum.
	always_ff @(posedge clk) begin
		prod_s1 <= mul[DATA_W-1:0];
		if (tok_s1.vld) begin
			acc_q <= tok_s1.first ? prod_s1 : acc_q + prod_s1;
		end
	end

	assign tok_o = tok_s1;
	assign acc   = acc_q;

endmodule

// ===== sv/integer_matrix_multiply.sv =====
// Loads of A or B give no result; the input stalls while a start runs.
// A start runs row by row: the feed state sends the row's inner elements of A into the cell row
// (min(MAX_DIM, 8) cells), the wait state holds until the last one leaves the last cell, then the
// drain state gives one result per cycle for the row while the output is not stalled.
// A dimension mismatch gives a single result, with status and last set, from the mismatch state.
// Reset clears control state and sets all dimension registers to 8; stores are undefined.
`include "integer_matrix_multiply_macros.svh"

module integer_matrix_multiply import imm_pkg::*; #(
	parameter int MAX_DIM = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  in_t               in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output out_t              out_data,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [DIM_W-1:0]  cfg_wdata
);

	localparam int DIM_CAP = (MAX_DIM < 8) ? MAX_DIM : 8;
	localparam int KW      = (DIM_CAP > 1) ? $clog2(DIM_CAP) : 1;
	localparam int DEPTH   = DIM_CAP * DIM_CAP;
	localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_FEED  = 5'b00010,
		ST_WAIT  = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_MISM  = 5'b10000
	} state_t;

	state_t             state_q;
	logic [DIM_W-1:0]   a_rows_q, a_cols_q, b_rows_q, b_cols_q;
	logic [KW-1:0]      m_last_q, inner_last_q, n_last_q;
	logic [KW-1:0]      i_q, k_q, j_q;
	logic               out_valid_q;
	out_t               out_q;
	logic               out_free;
	logic               load_ok;
	logic               a_we;
	logic [AW-1:0]      a_waddr;
	logic [AW-1:0]      a_raddr;
	logic [DATA_W-1:0]  a_mem [DEPTH];
	logic [DATA_W-1:0]  a_rd_q;
	logic               feed_vld_q;
	logic [KW-1:0]      feed_k_q;
	logic               feed_first_q;
	logic               feed_lastk_q;
	bwr_t               bwr;
	tok_t               tok [DIM_CAP+1];
	logic [DATA_W-1:0]  acc [DIM_CAP];

	function automatic logic [KW-1:0] dim_last(input logic [DIM_W-1:0] d);
		logic [KW-1:0] r;
		if (d == '0) begin
			r = '0;
		end else if (int'(d) > DIM_CAP) begin
			r = KW'(DIM_CAP - 1);
		end else begin
			r = KW'(int'(d) - 1);
		end
		return r;
	endfunction

	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign load_ok  = (int'(in_data.row) < MAX_DIM) && (int'(in_data.col) < MAX_DIM);

	assign a_we    = in_valid && !in_stall && (in_data.op == OP_LOAD_A) && load_ok;
	assign a_waddr = AW'(int'(in_data.row) * DIM_CAP + int'(in_data.col));
	assign a_raddr = AW'(int'(i_q) * DIM_CAP + int'(k_q));

	always_ff @(posedge clk) begin
		if (a_we) begin
			a_mem[a_waddr] <= in_data.value;
		end
		a_rd_q <= a_mem[a_raddr];
	end

	assign bwr = '{
		we:    in_valid && !in_stall && (in_data.op == OP_LOAD_B) && load_ok,
		row:   in_data.row,
		col:   in_data.col,
		value: in_data.value
	};

	assign tok[0] = '{
		vld:   feed_vld_q,
		a:     a_rd_q,
		k:     IDX_W'(feed_k_q),
		first: feed_first_q,
		lastk: feed_lastk_q
	};

	for (genvar g = 0; g < DIM_CAP; g++) begin : g_cell
		imm_cell #(
			.DIM_CAP(DIM_CAP),
			.J(g)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.tok_i(tok[g]),
			.bwr(bwr),
			.tok_o(tok[g+1]),
			.acc(acc[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			a_rows_q     <= DIM_RESET;
			a_cols_q     <= DIM_RESET;
			b_rows_q     <= DIM_RESET;
			b_cols_q     <= DIM_RESET;
			m_last_q     <= '0;
			inner_last_q <= '0;
			n_last_q     <= '0;
			i_q          <= '0;
			k_q          <= '0;
			j_q          <= '0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
			feed_vld_q   <= 1'b0;
			feed_k_q     <= '0;
			feed_first_q <= 1'b0;
			feed_lastk_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_A_ROWS: a_rows_q <= cfg_wdata;
					REG_A_COLS: a_cols_q <= cfg_wdata;
					REG_B_ROWS: b_rows_q <= cfg_wdata;
					REG_B_COLS: b_cols_q <= cfg_wdata;
				endcase
			end

			// drop the held result once it transfers; a new one below overrides
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			feed_vld_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && (in_data.op == OP_START)) begin
						if (a_cols_q != b_rows_q) begin
							state_q <= ST_MISM;
						end else begin
							m_last_q     <= dim_last(a_rows_q);
							inner_last_q <= dim_last(a_cols_q);
							n_last_q     <= dim_last(b_cols_q);
							i_q          <= '0;
							k_q          <= '0;
							state_q      <= ST_FEED;
						end
					end
				end
				ST_FEED: begin
					feed_vld_q   <= 1'b1;
					feed_k_q     <= k_q;
					feed_first_q <= (k_q == '0);
					feed_lastk_q <= (k_q == inner_last_q);
					if (k_q == inner_last_q) begin
						k_q     <= '0;
						state_q <= ST_WAIT;
					end else begin
						k_q <= k_q + KW'(1);
					end
				end
				ST_WAIT: begin
					// the row is done once its final element leaves the last cell
					if (tok[DIM_CAP].vld && tok[DIM_CAP].lastk) begin
						j_q     <= '0;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (out_free) begin
						out_valid_q    <= 1'b1;
						out_q.out_row  <= IDX_W'(i_q);
						out_q.out_col  <= IDX_W'(j_q);
						out_q.result   <= acc[j_q];
						out_q.last     <= (i_q == m_last_q) && (j_q == n_last_q);
						out_q.status   <= 1'b0;
						if (j_q == n_last_q) begin
							if (i_q == m_last_q) begin
								state_q <= ST_IDLE;
							end else begin
								i_q     <= i_q + KW'(1);
								state_q <= ST_FEED;
							end
						end else begin
							j_q <= j_q + KW'(1);
						end
					end
				end
				ST_MISM: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_q       <= '{out_row: '0, out_col: '0, result: '0,
						                 last: 1'b1, status: 1'b1};
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`IMM_ASSERT(a_mism_last, out_valid_q && out_q.status, out_q.last && (out_q.result == '0), "mismatch result must be last and zero")
	`IMM_ASSERT(a_more_pending, out_valid_q && !out_q.last, state_q != ST_IDLE, "idle while product results remain")
	`IMM_ASSERT(a_drain_quiet, state_q == ST_DRAIN, !tok[0].vld, "element entered cell row during drain")
	`IMM_ASSERT(a_tail_wait, tok[DIM_CAP].vld, state_q == ST_WAIT, "element left cell row outside wait")
	`IMM_ASSERT_NEXT(a_start_busy, in_valid && !in_stall && (in_data.op == OP_START), state_q != ST_IDLE, "start did not leave idle")

endmodule

// ===== tb/sv/integer_matrix_multiply_tb.sv =====
`timescale 1ns / 100ps

module integer_matrix_multiply_tb;
	import imm_pkg::*;

	localparam int MAX_DIM       = 8;
	localparam int DIM_CAP       = (MAX_DIM < 8) ? MAX_DIM : 8;
	localparam int STORE_DEPTH   = MAX_DIM * MAX_DIM;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int HOLD_CYCLES   = 300;
	localparam int QUIET_LIMIT   = 3000;
	localparam int SETTLE_CYCLES = 16;
	localparam int DRAIN_CYCLES  = 64;
	localparam int RANDOM_ITEMS  = 310;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_stall;
	in_t               in_data   = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	out_t              out_data;
	logic              cfg_we    = 1'b0;
	logic [CFG_AW-1:0] cfg_addr  = REG_A_ROWS;
	logic [DIM_W-1:0]  cfg_wdata = '0;

	class matmul_predictor;
		bit [DATA_W-1:0] a_mem[STORE_DEPTH];
		bit [DATA_W-1:0] b_mem[STORE_DEPTH];
		bit [DIM_W-1:0]  dim_reg[4];
		out_t            expected_elems[$];
		int              fail_count;

		function new();
			foreach (dim_reg[r])
				dim_reg[r] = DIM_RESET;
			fail_count = 0;
		endfunction

		function void write_reg(logic [CFG_AW-1:0] addr, logic [DIM_W-1:0] val);
			dim_reg[addr] = val;
		endfunction

		function int clamp_dim(bit [DIM_W-1:0] d);
			if (d == 0)
				return 1;
			if (d > DIM_CAP)
				return DIM_CAP;
			return int'(d);
		endfunction

		// raw register compare, before any saturation
		function bit dims_match();
			return dim_reg[REG_A_COLS] == dim_reg[REG_B_ROWS];
		endfunction

		function void accept_item(in_t item);
			int m, inner, n;
			bit [DATA_W-1:0] sum;
			out_t elem;
			case (item.op)
			OP_LOAD_A: begin
				if (item.row < MAX_DIM && item.col < MAX_DIM)
					a_mem[item.row * MAX_DIM + item.col] = item.value;
			end
			OP_LOAD_B: begin
				if (item.row < MAX_DIM && item.col < MAX_DIM)
					b_mem[item.row * MAX_DIM + item.col] = item.value;
			end
			OP_START: begin
				if (!dims_match()) begin
					elem = '0;
					elem.last = 1'b1;
					elem.status = 1'b1;
					expected_elems.push_back(elem);
				end else begin
					m = clamp_dim(dim_reg[REG_A_ROWS]);
					inner = clamp_dim(dim_reg[REG_A_COLS]);
					n = clamp_dim(dim_reg[REG_B_COLS]);
					for (int i = 0; i < m; i++) begin
						for (int j = 0; j < n; j++) begin
							sum = '0;
							// low 32 bits of each product, sum wraps
							for (int k = 0; k < inner; k++)
								sum = sum + a_mem[i * MAX_DIM + k] * b_mem[k * MAX_DIM + j];
							elem.out_row = IDX_W'(i);
							elem.out_col = IDX_W'(j);
							elem.result = sum;
							elem.last = (i == m - 1) && (j == n - 1);
							elem.status = 1'b0;
							expected_elems.push_back(elem);
						end
					end
				end
			end
			default: ;
			endcase
		endfunction

		function void check_field(string name, logic [DATA_W-1:0] want,
				logic [DATA_W-1:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				fail_count++;
			end
		endfunction

		function void check_element(out_t got);
			out_t want;
			if (expected_elems.size() == 0) begin
				$error("result with nothing pending: row %0d col %0d value %0h",
					got.out_row, got.out_col, got.result);
				fail_count++;
				return;
			end
			want = expected_elems.pop_front();
			check_field("out_row", want.out_row, got.out_row);
			check_field("out_col", want.out_col, got.out_col);
			check_field("result", want.result, got.result);
			check_field("last", want.last, got.last);
			check_field("status", want.status, got.status);
		endfunction
	endclass

	matmul_predictor board;

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int hold_ticket   = 0;
	int hold_seen     = 0;
	int hold_left     = 0;
	int quiet_cycles  = 0;
	int sent_items    = 0;
	bit a_written[STORE_DEPTH];
	bit b_written[STORE_DEPTH];

	integer_matrix_multiply #(.MAX_DIM(MAX_DIM)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// result side: check each transfer, then pick the stall for the next cycle
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0)
			board.check_element(out_data);
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (hold_ticket != hold_seen) begin
			hold_seen = hold_ticket;
			hold_left = HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic in_t make_item(logic [1:0] op, int row, int col,
			logic [DATA_W-1:0] value);
		in_t item;
		item.op = op;
		item.row = IDX_W'(row);
		item.col = IDX_W'(col);
		item.value = value;
		return item;
	endfunction

	function automatic logic [DATA_W-1:0] rand_value();
		case ($urandom_range(9))
		0: return 32'h8000_0000;
		1: return 32'h7fff_ffff;
		2: return 32'hffff_ffff;
		3: return '0;
		4, 5: return DATA_W'($urandom_range(20)) - 32'd10;
		default: return $urandom;
		endcase
	endfunction

	function automatic int rand_dim();
		case ($urandom_range(19))
		0: return 0;
		1: return 15;
		2: return 8;
		3: return $urandom_range(9, 14);
		default: return $urandom_range(1, 3);
		endcase
	endfunction

	task automatic send_item(in_t item);
		int idx;
		in_valid <= 1'b1;
		in_data <= item;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		board.accept_item(item);
		idx = item.row * MAX_DIM + item.col;
		if (item.op != OP_UNUSED)
			sent_items++;
		if (item.op == OP_LOAD_A)
			a_written[idx] = 1'b1;
		if (item.op == OP_LOAD_B)
			b_written[idx] = 1'b1;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic send_noise();
		send_item(make_item(OP_UNUSED, $urandom_range(7), $urandom_range(7), $urandom));
	endtask

	task automatic send_stray_load();
		send_item(make_item($urandom_range(1) ? OP_LOAD_B : OP_LOAD_A,
			$urandom_range(7), $urandom_range(7), rand_value()));
	endtask

	task automatic send_start();
		send_item(make_item(OP_START, $urandom_range(7), $urandom_range(7), rand_value()));
	endtask

	task automatic wait_idle(int cycles);
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.expected_elems.size() != 0)
			@(posedge clk);
		repeat (cycles) @(posedge clk);
	endtask

	task automatic write_dim(logic [CFG_AW-1:0] addr, int val);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= DIM_W'(val);
		@(posedge clk);
		board.write_reg(addr, DIM_W'(val));
	endtask

	task automatic set_dims(int a_r, int a_c, int b_r, int b_c);
		wait_idle(SETTLE_CYCLES);
		write_dim(REG_A_ROWS, a_r);
		write_dim(REG_A_COLS, a_c);
		write_dim(REG_B_ROWS, b_r);
		write_dim(REG_B_COLS, b_c);
		cfg_we <= 1'b0;
	endtask

	// load the operand region of the current shape, unwritten entries always
	task automatic fill_operands(bit reload_all);
		int m, inner, n, pick, slot;
		int loads[$];
		if (!board.dims_match())
			return;
		m = board.clamp_dim(board.dim_reg[REG_A_ROWS]);
		inner = board.clamp_dim(board.dim_reg[REG_A_COLS]);
		n = board.clamp_dim(board.dim_reg[REG_B_COLS]);
		for (int i = 0; i < m; i++)
			for (int k = 0; k < inner; k++)
				if (reload_all || !a_written[i * MAX_DIM + k] || $urandom_range(3) == 0)
					loads.push_back(i * MAX_DIM + k);
		for (int k = 0; k < inner; k++)
			for (int j = 0; j < n; j++)
				if (reload_all || !b_written[k * MAX_DIM + j] || $urandom_range(3) == 0)
					loads.push_back(STORE_DEPTH + k * MAX_DIM + j);
		while (loads.size() != 0) begin
			pick = $urandom_range(loads.size() - 1);
			slot = loads[pick];
			loads.delete(pick);
			if ($urandom_range(19) == 0)
				send_noise();
			if ($urandom_range(19) == 0)
				send_stray_load();
			if (slot < STORE_DEPTH)
				send_item(make_item(OP_LOAD_A, slot / MAX_DIM, slot % MAX_DIM, rand_value()));
			else
				send_item(make_item(OP_LOAD_B, (slot - STORE_DEPTH) / MAX_DIM,
					(slot - STORE_DEPTH) % MAX_DIM, rand_value()));
		end
	endtask

	task automatic run_sequence();
		int r;
		r = $urandom_range(99);
		if (r < 75) begin
			fill_operands(1'b1);
		end else if (r < 90) begin
			fill_operands(1'b0);
		end else begin
			repeat ($urandom_range(1, 4)) begin
				if ($urandom_range(1))
					send_noise();
				else
					send_stray_load();
			end
			fill_operands(1'b0);
		end
		send_start();
		if ($urandom_range(3) == 0)
			send_start();
	endtask

	initial begin
		int target, phase_end, phase, a_c, b_r;
		board = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// wrap of the largest products and sums
		set_dims(2, 1, 1, 2);
		send_item(make_item(OP_LOAD_A, 0, 0, 32'h7fff_ffff));
		send_item(make_item(OP_LOAD_A, 1, 0, 32'h8000_0000));
		send_item(make_item(OP_LOAD_B, 0, 0, 32'h7fff_ffff));
		send_item(make_item(OP_LOAD_B, 0, 1, 32'hffff_ffff));
		send_noise();
		// start ignores row, col and value
		send_item(make_item(OP_START, 7, 7, 32'hffff_ffff));
		send_item(make_item(OP_LOAD_A, 7, 7, 32'hffff_ffff));
		send_item(make_item(OP_LOAD_B, 7, 7, 32'h8000_0000));
		send_item(make_item(OP_START, 0, 0, 32'h0000_0000));
		set_dims(1, 3, 2, 1);
		send_start();
		// zero dims act as one
		set_dims(0, 0, 0, 0);
		send_start();
		// oversize dims saturate to the cap
		set_dims(9, 1, 1, 15);
		fill_operands(1'b0);
		send_start();

		// hold the result side off while starts keep coming
		target = sent_items + RANDOM_ITEMS;
		set_dims(4, 2, 2, 4);
		fill_operands(1'b1);
		hold_ticket <= hold_ticket + 1;
		repeat (6) begin
			send_start();
			send_stray_load();
		end

		phase = 0;
		while (sent_items < target) begin
			a_c = rand_dim();
			b_r = ($urandom_range(7) == 0) ? (a_c ^ $urandom_range(1, 15)) : a_c;
			set_dims(rand_dim(), a_c, b_r, rand_dim());
			case (phase % 4)
			0: begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
			1: begin
				send_idle_pct = 61;
				stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				stall_pct = 61;
			end
			default: begin
				send_idle_pct = 25;
				stall_pct = 25;
			end
			endcase
			phase_end = sent_items + 40;
			do
				run_sequence();
			while (sent_items < phase_end);
			phase++;
		end

		wait_idle(DRAIN_CYCLES);
		if (board.fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
